@@ rtl/core/dsuv_pkg.sv @@
package dsuv_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int QUEUE_DEPTH      = 4;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_Y = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_Z = 2'd2;

   localparam int RAD_W      = 66;
   localparam int ROOT_W     = 33;
   localparam int REM_W      = 36;
   localparam int SQRT_STEPS = 33;
   localparam int VEC_W      = 38;

   localparam logic [31:0] ATAN_TURNS [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   typedef struct packed {
      logic signed [31:0] particle_x;
      logic signed [31:0] particle_y;
      logic signed [31:0] particle_z;
      logic signed [31:0] turn_offset;
   } req_type;

   typedef struct packed {
      logic        [33:0] depth_distance;
      logic signed [31:0] u_coord;
      logic        [15:0] v_coord;
      logic               degenerate;
   } rsp_type;

   typedef struct packed {
      logic        [32:0] dmag_x;
      logic        [32:0] dmag_y;
      logic        [32:0] dmag_z;
      logic        [31:0] hmag_x;
      logic        [31:0] hmag_z;
      logic        [34:0] az_x;
      logic signed [35:0] az_y;
      logic               az_neg;
      logic signed [33:0] el_y;
      logic signed [31:0] turn_offset;
      logic               degenerate;
   } mid_type;

endpackage

@@ rtl/core/direction_to_sphere_uv.sv @@
// channel   ports                                      moves
// request   req_push, req_full, req_data               particle position, turn offset
// response  rsp_pop, rsp_empty, rsp_data               distance, u, v, degenerate flag
// csr       csr_valid, csr_ready, csr_index, csr_data  camera x, y, z
//
// One request enters per cycle while req_full is low; a response then passes through
// the 33-step square root chain followed by the CORDIC stages.
// Reset clears the queues and pipeline valids and zeroes the camera position.
// A full response queue freezes the back pipeline; the middle queue keeps the
// front taking requests until it fills too.
module direction_to_sphere_uv import dsuv_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  req_type                req_data,
   output logic                   req_full,
   input  logic                   rsp_pop,
   output rsp_type                rsp_data,
   output logic                   rsp_empty,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);
   logic    mid_push, mid_full, mid_pop, mid_empty;
   mid_type mid_wdata, mid_rdata;
   logic    out_push, out_full;
   rsp_type out_wdata;

   assign csr_ready = 1'b1;

   dsuv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .mid_push  (mid_push),
      .mid_data  (mid_wdata),
      .mid_full  (mid_full)
   );

   dsuv_queue #(
      .WIDTH ($bits(mid_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (mid_wdata),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   dsuv_back #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_rdata),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_wdata)
   );

   dsuv_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_wdata),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

endmodule

@@ rtl/core/dsuv_queue.sv @@
module dsuv_queue import dsuv_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ rtl/core/dsuv_front.sv @@
module dsuv_front import dsuv_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  req_type                req_data,
   output logic                   req_full,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data,
   output logic                   mid_push,
   output mid_type                mid_data,
   input  logic                   mid_full
);
   logic [31:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic        vld_ff, vld_in;
   mid_type     mid_ff, mid_in;
   logic        accept;

   logic [32:0] dfx, dfy, dfz;
   logic [34:0] dx, dy, dz, abs_x, abs_y, abs_z;
   logic [33:0] y4_mag;
   logic [35:0] dz_ext;

   assign req_full = vld_ff && mid_full;
   assign accept   = req_push && !req_full;
   assign mid_push = vld_ff && !mid_full;
   assign mid_data = mid_ff;

   function automatic logic [32:0] mag33(input logic [32:0] v);
      mag33 = v[32] ? (~v + 1'b1) : v;
   endfunction

   always_comb begin
      dfx = {req_data.particle_x[31], req_data.particle_x} - {cam_x_ff[31], cam_x_ff};
      dfy = {req_data.particle_y[31], req_data.particle_y} - {cam_y_ff[31], cam_y_ff};
      dfz = {req_data.particle_z[31], req_data.particle_z} - {cam_z_ff[31], cam_z_ff};
      dx = {cam_x_ff[31], cam_x_ff, 2'b00}
         - {{3{req_data.particle_x[31]}}, req_data.particle_x};
      dy = {cam_y_ff[31], cam_y_ff, 2'b00}
         - {{3{req_data.particle_y[31]}}, req_data.particle_y};
      dz = {cam_z_ff[31], cam_z_ff, 2'b00}
         - {{3{req_data.particle_z[31]}}, req_data.particle_z};
      abs_x  = dx[34] ? (~dx + 1'b1) : dx;
      abs_y  = dy[34] ? (~dy + 1'b1) : dy;
      abs_z  = dz[34] ? (~dz + 1'b1) : dz;
      y4_mag = {2'b00, abs_y[33:2]};
      dz_ext = {dz[34], dz};

      mid_in             = mid_ff;
      mid_in.dmag_x      = mag33(dfx);
      mid_in.dmag_y      = mag33(dfy);
      mid_in.dmag_z      = mag33(dfz);
      mid_in.hmag_x      = abs_x[33:2];
      mid_in.hmag_z      = abs_z[33:2];
      mid_in.az_x        = abs_x;
      mid_in.az_y        = dx[34] ? $signed(~dz_ext + 1'b1) : $signed(dz_ext);
      mid_in.az_neg      = dx[34];
      mid_in.el_y        = dy[34] ? $signed(~y4_mag + 1'b1) : $signed(y4_mag);
      mid_in.turn_offset = req_data.turn_offset;
      mid_in.degenerate  = (dx == '0) && (dz == '0);

      vld_in = vld_ff;
      if (accept) begin
         vld_in = 1'b1;
      end else if (mid_push) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= 1'b0;
         cam_x_ff <= '0;
         cam_y_ff <= '0;
         cam_z_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_CAMERA_X: cam_x_ff <= csr_data;
               CSR_CAMERA_Y: cam_y_ff <= csr_data;
               CSR_CAMERA_Z: cam_z_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mid_ff <= mid_in;
      end
   end

endmodule

@@ rtl/core/dsuv_back.sv @@
module dsuv_back import dsuv_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    mid_empty,
   input  mid_type mid_data,
   output logic    mid_pop,
   input  logic    out_full,
   output logic    out_push,
   output rsp_type out_data
);
   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic        [34:0] az_x;
      logic signed [35:0] az_y;
      logic               az_neg;
      logic signed [33:0] el_y;
      logic signed [31:0] turn_offset;
      logic               degenerate;
   } side_type;

   typedef struct packed {
      logic [64:0] sq_x;
      logic [64:0] sq_y;
      logic [64:0] sq_z;
      logic [63:0] sq_hx;
      logic [63:0] sq_hz;
      side_type    side;
   } prod_type;

   typedef struct packed {
      sqrt_type depth;
      sqrt_type hor;
      side_type side;
   } root_type;

   typedef struct packed {
      logic        [ROOT_W-1:0] depth;
      logic signed [VEC_W-1:0]  ax;
      logic signed [VEC_W-1:0]  ay;
      logic        [31:0]       a_acc;
      logic signed [VEC_W-1:0]  ex;
      logic signed [VEC_W-1:0]  ey;
      logic signed [33:0]       e_acc;
      logic signed [31:0]       turn_offset;
      logic                     degenerate;
   } rot_type;

   function automatic sqrt_type sqrt_step(input sqrt_type s);
      sqrt_type   n;
      logic [REM_W-1:0] r;
      logic [REM_W-1:0] trial;
      r     = {s.rem[REM_W-3:0], s.rad[RAD_W-1:RAD_W-2]};
      trial = {1'b0, s.root, 2'b01};
      n.rad = s.rad << 2;
      if (r >= trial) begin
         n.rem  = r - trial;
         n.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         n.rem  = r;
         n.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return n;
   endfunction

   logic     advance;
   logic     prod_vld_ff;
   prod_type prod_ff, prod_in;
   logic     root_vld_ff [SQRT_STEPS+1];
   root_type root_ff [SQRT_STEPS+1];
   root_type root_in [SQRT_STEPS+1];
   logic     rot_vld_ff [CORDIC_STEPS+1];
   rot_type  rot_ff [CORDIC_STEPS+1];
   rot_type  rot_in [CORDIC_STEPS+1];

   logic [65:0] mul_x, mul_y, mul_z;
   logic signed [33:0] u_sum;
   rot_type last;

   assign advance = !out_full;
   assign mid_pop = advance && !mid_empty;

   always_comb begin
      mul_x = mid_data.dmag_x * mid_data.dmag_x;
      mul_y = mid_data.dmag_y * mid_data.dmag_y;
      mul_z = mid_data.dmag_z * mid_data.dmag_z;
      prod_in.sq_x             = mul_x[64:0];
      prod_in.sq_y             = mul_y[64:0];
      prod_in.sq_z             = mul_z[64:0];
      prod_in.sq_hx            = mid_data.hmag_x * mid_data.hmag_x;
      prod_in.sq_hz            = mid_data.hmag_z * mid_data.hmag_z;
      prod_in.side.az_x        = mid_data.az_x;
      prod_in.side.az_y        = mid_data.az_y;
      prod_in.side.az_neg      = mid_data.az_neg;
      prod_in.side.el_y        = mid_data.el_y;
      prod_in.side.turn_offset = mid_data.turn_offset;
      prod_in.side.degenerate  = mid_data.degenerate;
   end

   always_comb begin
      root_in[0].depth.rad  = {1'b0, prod_ff.sq_x} + {1'b0, prod_ff.sq_y}
                            + {1'b0, prod_ff.sq_z};
      root_in[0].depth.rem  = '0;
      root_in[0].depth.root = '0;
      root_in[0].hor.rad    = {2'b00, prod_ff.sq_hx} + {2'b00, prod_ff.sq_hz};
      root_in[0].hor.rem    = '0;
      root_in[0].hor.root   = '0;
      root_in[0].side       = prod_ff.side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff    <= 1'b0;
         root_vld_ff[0] <= 1'b0;
      end else if (advance) begin
         prod_vld_ff    <= mid_pop;
         root_vld_ff[0] <= prod_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff    <= prod_in;
         root_ff[0] <= root_in[0];
      end
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      always_comb begin
         root_in[k+1].depth = sqrt_step(root_ff[k].depth);
         root_in[k+1].hor   = sqrt_step(root_ff[k].hor);
         root_in[k+1].side  = root_ff[k].side;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            root_vld_ff[k+1] <= 1'b0;
         end else if (advance) begin
            root_vld_ff[k+1] <= root_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            root_ff[k+1] <= root_in[k+1];
         end
      end
   end

   always_comb begin
      rot_in[0].depth       = root_ff[SQRT_STEPS].depth.root;
      rot_in[0].ax          = $signed({3'b000, root_ff[SQRT_STEPS].side.az_x});
      rot_in[0].ay          = $signed({{2{root_ff[SQRT_STEPS].side.az_y[35]}},
                                       root_ff[SQRT_STEPS].side.az_y});
      rot_in[0].a_acc       = root_ff[SQRT_STEPS].side.az_neg ? 32'h8000_0000 : 32'h0;
      rot_in[0].ex          = $signed({5'b00000, root_ff[SQRT_STEPS].hor.root});
      rot_in[0].ey          = $signed({{4{root_ff[SQRT_STEPS].side.el_y[33]}},
                                       root_ff[SQRT_STEPS].side.el_y});
      rot_in[0].e_acc       = 34'sh0_8000_0000;
      rot_in[0].turn_offset = root_ff[SQRT_STEPS].side.turn_offset;
      rot_in[0].degenerate  = root_ff[SQRT_STEPS].side.degenerate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_vld_ff[0] <= 1'b0;
      end else if (advance) begin
         rot_vld_ff[0] <= root_vld_ff[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rot_ff[0] <= rot_in[0];
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      logic signed [VEC_W-1:0] ax_sh, ay_sh, ex_sh, ey_sh;
      logic signed [33:0]      step_turn;

      always_comb begin
         ax_sh     = $signed(rot_ff[i].ax) >>> i;
         ay_sh     = $signed(rot_ff[i].ay) >>> i;
         ex_sh     = $signed(rot_ff[i].ex) >>> i;
         ey_sh     = $signed(rot_ff[i].ey) >>> i;
         step_turn = $signed({2'b00, ATAN_TURNS[i]});
         rot_in[i+1] = rot_ff[i];
         if (!rot_ff[i].ay[VEC_W-1]) begin
            rot_in[i+1].ax    = rot_ff[i].ax + ay_sh;
            rot_in[i+1].ay    = rot_ff[i].ay - ax_sh;
            rot_in[i+1].a_acc = rot_ff[i].a_acc + ATAN_TURNS[i];
         end else begin
            rot_in[i+1].ax    = rot_ff[i].ax - ay_sh;
            rot_in[i+1].ay    = rot_ff[i].ay + ax_sh;
            rot_in[i+1].a_acc = rot_ff[i].a_acc - ATAN_TURNS[i];
         end
         if (!rot_ff[i].ey[VEC_W-1]) begin
            rot_in[i+1].ex    = rot_ff[i].ex + ey_sh;
            rot_in[i+1].ey    = rot_ff[i].ey - ex_sh;
            rot_in[i+1].e_acc = rot_ff[i].e_acc + step_turn;
         end else begin
            rot_in[i+1].ex    = rot_ff[i].ex - ey_sh;
            rot_in[i+1].ey    = rot_ff[i].ey + ex_sh;
            rot_in[i+1].e_acc = rot_ff[i].e_acc - step_turn;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rot_vld_ff[i+1] <= 1'b0;
         end else if (advance) begin
            rot_vld_ff[i+1] <= rot_vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rot_ff[i+1] <= rot_in[i+1];
         end
      end
   end

   assign last     = rot_ff[CORDIC_STEPS];
   assign out_push = advance && rot_vld_ff[CORDIC_STEPS];

   always_comb begin
      u_sum = $signed({18'b0, last.a_acc[31:16]})
            + $signed({{2{last.turn_offset[31]}}, last.turn_offset});
      out_data.depth_distance = {1'b0, last.depth};
      out_data.degenerate     = last.degenerate;
      if (last.degenerate) begin
         out_data.u_coord = last.turn_offset;
         out_data.v_coord = 16'h8000;
      end else begin
         if (u_sum > 34'sh0_7FFF_FFFF) begin
            out_data.u_coord = 32'sh7FFF_FFFF;
         end else if (u_sum < -34'sh0_8000_0000) begin
            out_data.u_coord = 32'sh8000_0000;
         end else begin
            out_data.u_coord = u_sum[31:0];
         end
         if (last.e_acc[33]) begin
            out_data.v_coord = 16'h0000;
         end else if (last.e_acc[32]) begin
            out_data.v_coord = 16'hFFFF;
         end else begin
            out_data.v_coord = last.e_acc[31:16];
         end
      end
   end

endmodule
